// File: design/kfwrl_pkg.sv
// ----------------------------------------------------------------------------
// kfwrl_pkg: shared types and constants of the keyed fixed-window rate limiter
// Holds the controller state type, the configuration register indexes and
// the fixed field widths of the request and table entries.
// ----------------------------------------------------------------------------
package kfwrl_pkg;

	// Fixed field widths.
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned COUNT_W  = 8;
	localparam int unsigned LIMIT_W  = 8;
	localparam int unsigned WINDOW_W = 16;
	localparam int unsigned PORT_KEY_W = 32;

	// Configuration port.
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_RATE_LIMIT     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SECONDS = 2'd1;

	localparam logic [LIMIT_W-1:0]  RATE_LIMIT_RESET     = 8'd5;
	localparam logic [WINDOW_W-1:0] WINDOW_SECONDS_RESET = 16'd3;

	// Controller states.
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN
	} state_t;

endpackage

// File: design/keyed_fixed_window_rate_limiter.sv
// ----------------------------------------------------------------------------
// Timing: a request that hits table entry i shows done once that entry's read
// data has been checked; a miss shows done after the last entry is checked. The
// table walk does one memory read per cycle; a new request may start in
// the cycle that done is shown. Results cannot be stalled by the receiver.
// Reset: the table memory is cleared entry by entry, busy held high.
// ----------------------------------------------------------------------------
// keyed_fixed_window_rate_limiter
// Per-key fixed-window request counter over a table kept in one synchronous
// memory. Each request walks the table in index order; a hit updates the
// entry's window and count, a miss claims the first empty or oldest entry.
// ----------------------------------------------------------------------------
module keyed_fixed_window_rate_limiter
	import kfwrl_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = 256,
	parameter int unsigned KEY_WIDTH     = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [PORT_KEY_W-1:0]  user_key,
	input  logic [PORT_KEY_W-1:0]  room_key,
	input  logic [TIME_W-1:0]      now_seconds,
	output logic                   done,
	output logic                   allowed,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned KEY_USED = (KEY_WIDTH < PORT_KEY_W) ? KEY_WIDTH : PORT_KEY_W;
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

	typedef struct packed {
		logic [KEY_WIDTH-1:0] user;
		logic [KEY_WIDTH-1:0] room;
		logic [TIME_W-1:0]    start;
		logic [COUNT_W-1:0]   count;
	} entry_t;

	// Table memory and its read data register.
	entry_t mem_q [TABLE_ENTRIES];
	entry_t rd_word_s1;

	state_t state_q, state_d;

	logic [LIMIT_W-1:0]   rate_limit_q;
	logic [WINDOW_W-1:0]  window_q;

	logic [KEY_WIDTH-1:0] user_q, room_q;
	logic [TIME_W-1:0]    now_q;
	logic [KEY_WIDTH-1:0] user_k, room_k;

	logic [AW-1:0]        addr_q;
	logic                 issue_done_q;
	logic                 vld_s1;
	logic [AW-1:0]        idx_s1;

	logic                 have_empty_q;
	logic [AW-1:0]        empty_slot_q;
	logic [TIME_W-1:0]    oldest_start_q;
	logic [AW-1:0]        oldest_slot_q;

	logic                 done_q, allowed_q;

	logic                 accept, rd_en, eval, hit, is_empty, first, older;
	logic                 finish, allowed_d;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	entry_t               wr_word;

	logic [TIME_W-1:0]    age;
	logic                 expired;
	logic [COUNT_W-1:0]   count_base;
	logic                 deny;
	logic [AW-1:0]        miss_slot;

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign allowed   = allowed_q;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Keys are cut to the key width and zero-extended where it is wider.
	always_comb begin
		user_k = '0;
		room_k = '0;
		user_k[KEY_USED-1:0] = user_key[KEY_USED-1:0];
		room_k[KEY_USED-1:0] = room_key[KEY_USED-1:0];
	end

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_limit_q <= RATE_LIMIT_RESET;
			window_q     <= WINDOW_SECONDS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RATE_LIMIT:     rate_limit_q <= cfg_data[LIMIT_W-1:0];
				REG_WINDOW_SECONDS: window_q     <= cfg_data;
				default:            ;
			endcase
		end
	end

	// Table memory: one read and one write port, read data registered.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_word;
		end
		if (rd_en) begin
			rd_word_s1 <= mem_q[addr_q];
		end
	end

	// Evaluation of the entry read in the previous cycle.
	assign rd_en    = (state_q == ST_SCAN) && !issue_done_q;
	assign eval     = (state_q == ST_SCAN) && vld_s1;
	assign hit      = eval && (rd_word_s1.user == user_q) && (rd_word_s1.room == room_q);
	assign is_empty = (rd_word_s1.user == '0) && (rd_word_s1.room == '0);
	assign first    = (idx_s1 == '0);
	assign older    = first || (rd_word_s1.start < oldest_start_q);

	// Window restart and limit check for a hit.
	assign age        = now_q - rd_word_s1.start;
	assign expired    = age >= TIME_W'(window_q);
	assign count_base = expired ? '0 : rd_word_s1.count;
	assign deny       = count_base >= rate_limit_q;

	// Slot claimed on a miss, including the last entry just read.
	always_comb begin
		if (have_empty_q) begin
			miss_slot = empty_slot_q;
		end else if (is_empty || older) begin
			miss_slot = idx_s1;
		end else begin
			miss_slot = oldest_slot_q;
		end
	end

	// Next state, memory writes and the result.
	always_comb begin
		state_d   = state_q;
		wr_en     = 1'b0;
		wr_addr   = addr_q;
		wr_word   = '0;
		finish    = 1'b0;
		allowed_d = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
				if (addr_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					wr_en         = 1'b1;
					wr_addr       = idx_s1;
					wr_word.user  = user_q;
					wr_word.room  = room_q;
					wr_word.start = expired ? now_q : rd_word_s1.start;
					wr_word.count = deny ? count_base : COUNT_W'(count_base + 1'b1);
					allowed_d     = !deny;
					finish        = 1'b1;
					state_d       = ST_IDLE;
				end else if (eval && (idx_s1 == LAST_IDX)) begin
					wr_en         = 1'b1;
					wr_addr       = miss_slot;
					wr_word.user  = user_q;
					wr_word.room  = room_q;
					wr_word.start = now_q;
					wr_word.count = COUNT_W'(1);
					finish        = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Address counter, read tracking and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q       <= '0;
			issue_done_q <= 1'b0;
			vld_s1       <= 1'b0;
			done_q       <= 1'b0;
			allowed_q    <= 1'b0;
			have_empty_q <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			done_q <= finish;
			if (finish) begin
				allowed_q <= allowed_d;
			end
			if (accept) begin
				addr_q       <= '0;
				issue_done_q <= 1'b0;
				have_empty_q <= 1'b0;
			end else if ((state_q == ST_CLEAR) || rd_en) begin
				addr_q <= AW'(addr_q + 1'b1);
				if (rd_en && (addr_q == LAST_IDX)) begin
					issue_done_q <= 1'b1;
				end
			end
			if (eval && !hit && !have_empty_q && is_empty) begin
				have_empty_q <= 1'b1;
			end
		end
	end

	// Request fields and scan trackers.
	always_ff @(posedge clk) begin
		if (accept) begin
			user_q <= user_k;
			room_q <= room_k;
			now_q  <= now_seconds;
		end
		idx_s1 <= addr_q;
		if (eval && !hit) begin
			if (!have_empty_q && is_empty) begin
				empty_slot_q <= idx_s1;
			end
			if (older) begin
				oldest_start_q <= rd_word_s1.start;
				oldest_slot_q  <= idx_s1;
			end
		end
	end

endmodule
